// ===== rtl/core/p2rgb_pkg.sv =====
package p2rgb_pkg;

	localparam logic [2:0] FMT_YUV422_10 = 3'd0;
	localparam logic [2:0] FMT_YUV422_12 = 3'd1;
	localparam logic [2:0] FMT_YUV444_10 = 3'd2;
	localparam logic [2:0] FMT_YUV444_12 = 3'd3;
	localparam logic [2:0] FMT_GBR_10    = 3'd4;
	localparam logic [2:0] FMT_GBR_12    = 3'd5;
	localparam logic [2:0] FMT_YUV420_8  = 3'd6;

	localparam logic REG_PIXEL_FORMAT  = 1'b0;
	localparam logic REG_FRAME_PRESENT = 1'b1;

	localparam int SAMPLE_W = 16;
	localparam int PIX_W    = 8;
	// products and sums stay inside +/-2^19
	localparam int ACC_W    = 20;
	localparam int SHR_W    = ACC_W - 8;

	localparam logic signed [ACC_W-1:0] Y_OFFSET   = 20'sd16;
	localparam logic signed [ACC_W-1:0] C_OFFSET   = 20'sd128;
	localparam logic signed [ACC_W-1:0] K_Y        = 20'sd298;
	localparam logic signed [ACC_W-1:0] K_RV       = 20'sd409;
	localparam logic signed [ACC_W-1:0] K_GU       = 20'sd100;
	localparam logic signed [ACC_W-1:0] K_GV       = 20'sd208;
	localparam logic signed [ACC_W-1:0] K_BU       = 20'sd516;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = 20'sd128;

	typedef enum logic [1:0] {
		MODE_BLACK,
		MODE_YUV,
		MODE_GBR,
		MODE_LUMA
	} mode_t;

	typedef struct packed {
		logic  valid;
		mode_t mode;
	} ctl_t;

endpackage

// ===== rtl/core/planar_pixel_to_rgb888.sv =====
// Planar pixel to RGB888 converter.
// Input: pulse start with the three plane samples of one pixel; a word is
// taken at every edge where start is high and busy is low. busy is always
// low, so a new pixel may be given every cycle.
// Output: done is high for one cycle with red/green/blue after the s1,
// s2, s3 and output registers. One pixel per clock sustained, set by a
// four-stage pipeline: sample reduction, constant multiplies, sums with
// floor shift, clamp and select. The receiver cannot hold results off.
// Config: cfg_we writes cfg_data into register cfg_index
// (0 pixel_format, 1 frame_present). Write only while no pixel is in
// flight; a pixel uses the setting present when it was taken.
// Reset: arst_n clears the pipeline valid bits, pixel_format returns to
// 8-bit 4:2:0 and frame_present to 1. Unknown format or an absent frame
// gives black.
module planar_pixel_to_rgb888 (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [2:0]                             cfg_data,
	input  logic [p2rgb_pkg::SAMPLE_W-1:0]         sample_luma_or_green,
	input  logic [p2rgb_pkg::SAMPLE_W-1:0]         sample_cb_or_blue,
	input  logic [p2rgb_pkg::SAMPLE_W-1:0]         sample_cr_or_red,
	output logic                                   done,
	output logic [p2rgb_pkg::PIX_W-1:0]            red,
	output logic [p2rgb_pkg::PIX_W-1:0]            green,
	output logic [p2rgb_pkg::PIX_W-1:0]            blue
);

	logic [2:0]                            pixel_format_q;
	logic                                  frame_present_q;
	logic                                  take;
	p2rgb_pkg::ctl_t                       ctl_s1, ctl_s2;
	logic [p2rgb_pkg::PIX_W-1:0]           s0_s1, s1_s1, s2_s1;
	logic [p2rgb_pkg::PIX_W-1:0]           s0_s2, s1_s2, s2_s2;
	logic signed [p2rgb_pkg::ACC_W-1:0]    yc_s2, rv_s2, gu_s2, gv_s2, bu_s2;

	assign busy = 1'b0;
	assign take = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q  <= p2rgb_pkg::FMT_YUV420_8;
			frame_present_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				p2rgb_pkg::REG_PIXEL_FORMAT:  pixel_format_q  <= cfg_data;
				p2rgb_pkg::REG_FRAME_PRESENT: frame_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	p2rgb_unpack u_unpack (
		.clk                  (clk),
		.arst_n               (arst_n),
		.take                 (take),
		.pixel_format         (pixel_format_q),
		.frame_present        (frame_present_q),
		.sample_luma_or_green (sample_luma_or_green),
		.sample_cb_or_blue    (sample_cb_or_blue),
		.sample_cr_or_red     (sample_cr_or_red),
		.ctl_s1               (ctl_s1),
		.s0_s1                (s0_s1),
		.s1_s1                (s1_s1),
		.s2_s1                (s2_s1)
	);

	p2rgb_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.s0_s1  (s0_s1),
		.s1_s1  (s1_s1),
		.s2_s1  (s2_s1),
		.ctl_s2 (ctl_s2),
		.s0_s2  (s0_s2),
		.s1_s2  (s1_s2),
		.s2_s2  (s2_s2),
		.yc_s2  (yc_s2),
		.rv_s2  (rv_s2),
		.gu_s2  (gu_s2),
		.gv_s2  (gv_s2),
		.bu_s2  (bu_s2)
	);

	p2rgb_sum_clamp u_sum_clamp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.s0_s2  (s0_s2),
		.s1_s2  (s1_s2),
		.s2_s2  (s2_s2),
		.yc_s2  (yc_s2),
		.rv_s2  (rv_s2),
		.gu_s2  (gu_s2),
		.gv_s2  (gv_s2),
		.bu_s2  (bu_s2),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##4 done)
		else $error("taken word did not come out after four cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid |-> $past(ctl_s1.valid))
		else $error("stage two valid without stage one word");

	a_black_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && ctl_s1.mode == p2rgb_pkg::MODE_BLACK |-> ##3
		(red == '0 && green == '0 && blue == '0))
		else $error("black word came out with nonzero color");

endmodule

// ===== rtl/core/p2rgb_unpack.sv =====
module p2rgb_unpack (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   take,
	input  logic [2:0]                             pixel_format,
	input  logic                                   frame_present,
	input  logic [p2rgb_pkg::SAMPLE_W-1:0]         sample_luma_or_green,
	input  logic [p2rgb_pkg::SAMPLE_W-1:0]         sample_cb_or_blue,
	input  logic [p2rgb_pkg::SAMPLE_W-1:0]         sample_cr_or_red,
	output p2rgb_pkg::ctl_t                        ctl_s1,
	output logic [p2rgb_pkg::PIX_W-1:0]            s0_s1,
	output logic [p2rgb_pkg::PIX_W-1:0]            s1_s1,
	output logic [p2rgb_pkg::PIX_W-1:0]            s2_s1
);

	logic [1:0]         depth_sel;
	p2rgb_pkg::mode_t   mode;

	function automatic logic [p2rgb_pkg::PIX_W-1:0] reduce(
		input logic [p2rgb_pkg::SAMPLE_W-1:0] s,
		input logic [1:0]                      sel
	);
		case (sel)
			2'd1:    reduce = s[9:2];
			2'd2:    reduce = s[11:4];
			default: reduce = s[7:0];
		endcase
	endfunction

	always_comb begin
		case (pixel_format)
			p2rgb_pkg::FMT_YUV422_10, p2rgb_pkg::FMT_YUV444_10,
			p2rgb_pkg::FMT_GBR_10:    depth_sel = 2'd1;
			p2rgb_pkg::FMT_YUV422_12, p2rgb_pkg::FMT_YUV444_12,
			p2rgb_pkg::FMT_GBR_12:    depth_sel = 2'd2;
			default:                  depth_sel = 2'd0;
		endcase
		if (!frame_present) begin
			mode = p2rgb_pkg::MODE_BLACK;
		end else begin
			case (pixel_format)
				p2rgb_pkg::FMT_YUV422_10, p2rgb_pkg::FMT_YUV422_12,
				p2rgb_pkg::FMT_YUV444_10, p2rgb_pkg::FMT_YUV444_12:
					mode = p2rgb_pkg::MODE_YUV;
				p2rgb_pkg::FMT_GBR_10, p2rgb_pkg::FMT_GBR_12:
					mode = p2rgb_pkg::MODE_GBR;
				p2rgb_pkg::FMT_YUV420_8:
					mode = p2rgb_pkg::MODE_LUMA;
				default:
					mode = p2rgb_pkg::MODE_BLACK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, mode: p2rgb_pkg::MODE_BLACK};
		end else begin
			ctl_s1 <= '{valid: take, mode: mode};
		end
	end

	always_ff @(posedge clk) begin
		s0_s1 <= reduce(sample_luma_or_green, depth_sel);
		s1_s1 <= reduce(sample_cb_or_blue, depth_sel);
		s2_s1 <= reduce(sample_cr_or_red, depth_sel);
	end

endmodule

// ===== rtl/core/p2rgb_mult.sv =====
module p2rgb_mult (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  p2rgb_pkg::ctl_t                        ctl_s1,
	input  logic [p2rgb_pkg::PIX_W-1:0]            s0_s1,
	input  logic [p2rgb_pkg::PIX_W-1:0]            s1_s1,
	input  logic [p2rgb_pkg::PIX_W-1:0]            s2_s1,
	output p2rgb_pkg::ctl_t                        ctl_s2,
	output logic [p2rgb_pkg::PIX_W-1:0]            s0_s2,
	output logic [p2rgb_pkg::PIX_W-1:0]            s1_s2,
	output logic [p2rgb_pkg::PIX_W-1:0]            s2_s2,
	output logic signed [p2rgb_pkg::ACC_W-1:0]     yc_s2,
	output logic signed [p2rgb_pkg::ACC_W-1:0]     rv_s2,
	output logic signed [p2rgb_pkg::ACC_W-1:0]     gu_s2,
	output logic signed [p2rgb_pkg::ACC_W-1:0]     gv_s2,
	output logic signed [p2rgb_pkg::ACC_W-1:0]     bu_s2
);

	logic signed [p2rgb_pkg::ACC_W-1:0] c, d, e;

	assign c = $signed({{(p2rgb_pkg::ACC_W-p2rgb_pkg::PIX_W){1'b0}}, s0_s1})
		- p2rgb_pkg::Y_OFFSET;
	assign d = $signed({{(p2rgb_pkg::ACC_W-p2rgb_pkg::PIX_W){1'b0}}, s1_s1})
		- p2rgb_pkg::C_OFFSET;
	assign e = $signed({{(p2rgb_pkg::ACC_W-p2rgb_pkg::PIX_W){1'b0}}, s2_s1})
		- p2rgb_pkg::C_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '{valid: 1'b0, mode: p2rgb_pkg::MODE_BLACK};
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		s0_s2 <= s0_s1;
		s1_s2 <= s1_s1;
		s2_s2 <= s2_s1;
		yc_s2 <= c * p2rgb_pkg::K_Y;
		rv_s2 <= e * p2rgb_pkg::K_RV;
		gu_s2 <= d * p2rgb_pkg::K_GU;
		gv_s2 <= e * p2rgb_pkg::K_GV;
		bu_s2 <= d * p2rgb_pkg::K_BU;
	end

endmodule

// ===== rtl/core/p2rgb_sum_clamp.sv =====
module p2rgb_sum_clamp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  p2rgb_pkg::ctl_t                        ctl_s2,
	input  logic [p2rgb_pkg::PIX_W-1:0]            s0_s2,
	input  logic [p2rgb_pkg::PIX_W-1:0]            s1_s2,
	input  logic [p2rgb_pkg::PIX_W-1:0]            s2_s2,
	input  logic signed [p2rgb_pkg::ACC_W-1:0]     yc_s2,
	input  logic signed [p2rgb_pkg::ACC_W-1:0]     rv_s2,
	input  logic signed [p2rgb_pkg::ACC_W-1:0]     gu_s2,
	input  logic signed [p2rgb_pkg::ACC_W-1:0]     gv_s2,
	input  logic signed [p2rgb_pkg::ACC_W-1:0]     bu_s2,
	output logic                                   done,
	output logic [p2rgb_pkg::PIX_W-1:0]            red,
	output logic [p2rgb_pkg::PIX_W-1:0]            green,
	output logic [p2rgb_pkg::PIX_W-1:0]            blue
);

	p2rgb_pkg::ctl_t                       ctl_s3;
	logic [p2rgb_pkg::PIX_W-1:0]           s0_s3, s1_s3, s2_s3;
	logic signed [p2rgb_pkg::SHR_W-1:0]    r_s3, g_s3, b_s3;
	logic signed [p2rgb_pkg::ACC_W-1:0]    r_sum, g_sum, b_sum;
	logic [p2rgb_pkg::PIX_W-1:0]           r_sat, g_sat, b_sat;
	logic [p2rgb_pkg::PIX_W-1:0]           r_nxt, g_nxt, b_nxt;

	function automatic logic [p2rgb_pkg::PIX_W-1:0] sat8(
		input logic signed [p2rgb_pkg::SHR_W-1:0] v
	);
		if (v < 0) begin
			sat8 = '0;
		end else if (v > $signed(p2rgb_pkg::SHR_W'(255))) begin
			sat8 = '1;
		end else begin
			sat8 = v[p2rgb_pkg::PIX_W-1:0];
		end
	endfunction

	assign r_sum = yc_s2 + rv_s2 + p2rgb_pkg::ROUND_HALF;
	assign g_sum = yc_s2 - gu_s2 - gv_s2 + p2rgb_pkg::ROUND_HALF;
	assign b_sum = yc_s2 + bu_s2 + p2rgb_pkg::ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '{valid: 1'b0, mode: p2rgb_pkg::MODE_BLACK};
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	// dropping the low byte of a two's complement value is a floor divide
	always_ff @(posedge clk) begin
		s0_s3 <= s0_s2;
		s1_s3 <= s1_s2;
		s2_s3 <= s2_s2;
		r_s3  <= r_sum[p2rgb_pkg::ACC_W-1:8];
		g_s3  <= g_sum[p2rgb_pkg::ACC_W-1:8];
		b_s3  <= b_sum[p2rgb_pkg::ACC_W-1:8];
	end

	assign r_sat = sat8(r_s3);
	assign g_sat = sat8(g_s3);
	assign b_sat = sat8(b_s3);

	always_comb begin
		case (ctl_s3.mode)
			p2rgb_pkg::MODE_YUV: begin
				r_nxt = r_sat;
				g_nxt = g_sat;
				b_nxt = b_sat;
			end
			p2rgb_pkg::MODE_GBR: begin
				r_nxt = s2_s3;
				g_nxt = s0_s3;
				b_nxt = s1_s3;
			end
			p2rgb_pkg::MODE_LUMA: begin
				r_nxt = s0_s3;
				g_nxt = s0_s3;
				b_nxt = s0_s3;
			end
			default: begin
				r_nxt = '0;
				g_nxt = '0;
				b_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		red   <= r_nxt;
		green <= g_nxt;
		blue  <= b_nxt;
	end

endmodule
